FILE: rtl/lft_pkg.sv
// lft_pkg: shared types and codes for the lfu frame table
// no dependencies
package lft_pkg;

    localparam int unsigned FRAME_W  = 16;
    localparam int unsigned PROC_W   = 15;
    localparam int unsigned SFREQ_W  = 16;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_READ   = 2'd1,
        ACT_WRITE  = 2'd2,
        ACT_EVICT  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic lookup;    // remove the chosen entry and latch its fields
        logic place;     // insert the staged entry in order
        logic finish;    // latch the result item
    } t_lft_cmd;

    // datapath to controller
    typedef struct packed {
        logic    empty;
        logic    full;
        logic    hit;
        t_action action;
    } t_lft_sts;

endpackage

FILE: rtl/lft_datapath.sv
// lft_datapath: sorted shift chain of frame entries plus staging and result registers
// depends on lft_pkg
module lft_datapath
    import lft_pkg::*;
#(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned FREQ_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lft_cmd             i_cmd,
    output t_lft_sts             o_sts,
    input  logic [1:0]           i_action,
    input  logic [FRAME_W-1:0]   i_frame_index,
    input  logic [PROC_W-1:0]    i_process_id,
    input  logic [SFREQ_W-1:0]   i_start_frequency,
    input  logic                 i_start_dirty,
    input  t_status              i_status,
    output logic [1:0]           o_status,
    output logic [FRAME_W-1:0]   o_out_frame_index,
    output logic [PROC_W-1:0]    o_out_process_id,
    output logic [SFREQ_W-1:0]   o_out_frequency,
    output logic                 o_out_dirty,
    output logic [COUNT_W-1:0]   o_entry_count
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;

    // entry chain, slot 0 is the head
    logic [FRAME_W-1:0]   r_fr [CAPACITY];
    logic [PROC_W-1:0]    r_pr [CAPACITY];
    logic [FREQ_BITS-1:0] r_fq [CAPACITY];
    logic                 r_dt [CAPACITY];
    logic [CNT_W-1:0]     r_held;

    // staged item
    t_action              r_act;
    logic [FRAME_W-1:0]   r_s_fr;
    logic [PROC_W-1:0]    r_s_pr;
    logic [FREQ_BITS-1:0] r_s_fq;
    logic                 r_s_dt;
    logic                 r_hit;

    logic [CAPACITY-1:0]  match;
    logic [CAPACITY-1:0]  first;
    logic [CAPACITY-1:0]  live;
    logic [CAPACITY-1:0]  gt;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     rm_idx;
    logic [IDX_W-1:0]     tail_idx;
    logic [FREQ_BITS-1:0] in_fq;
    logic [FREQ_BITS-1:0] bumped;

    assign tail_idx = IDX_W'(r_held - CNT_W'(1));

    // compare every slot in parallel
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            live[i]  = (CNT_W'(i) < r_held);
            match[i] = live[i] && (r_fr[i] == r_s_fr);
            gt[i]    = live[i] && (r_fq[i] > r_s_fq);
        end
        first = match & ~(match - CAPACITY'(1));
        for (int i = 0; i < CAPACITY; i++) begin
            if (first[i]) begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign rm_idx = (r_act == ACT_EVICT) ? tail_idx : hit_idx;

    // input frequency clipped to the stored width; the chosen entry's frequency bumped with saturation
    always_comb begin
        if (FREQ_BITS < SFREQ_W && (i_start_frequency >> FREQ_BITS) != '0) begin
            in_fq = FREQ_MAX;
        end else begin
            in_fq = FREQ_BITS'(i_start_frequency);
        end
        bumped = (r_fq[rm_idx] == FREQ_MAX) ? FREQ_MAX : r_fq[rm_idx] + 1'b1;
    end

    assign o_sts.empty  = (r_held == '0);
    assign o_sts.full   = (r_held >= CNT_W'(CAPACITY));
    assign o_sts.hit    = r_hit;
    assign o_sts.action = r_act;

    // staging registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.load) begin
            r_act  <= t_action'(i_action);
            r_s_fr <= i_frame_index;
            r_s_pr <= i_process_id;
            r_s_fq <= (in_fq == FREQ_MAX) ? FREQ_MAX : in_fq + 1'b1;
            r_s_dt <= i_start_dirty;
            r_hit  <= 1'b0;
        end else if (i_cmd.lookup) begin
            r_hit  <= (r_act == ACT_EVICT) || (match != '0);
            r_s_fr <= r_fr[rm_idx];
            r_s_pr <= r_pr[rm_idx];
            r_s_fq <= (r_act == ACT_EVICT) ? r_fq[rm_idx] : bumped;
            r_s_dt <= r_dt[rm_idx] | (r_act == ACT_WRITE);
        end else if (i_cmd.place) begin
            // a placed entry marks the step as done
            r_hit  <= 1'b1;
        end
    end

    // chain shifts: close the gap on removal, open one on insertion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.lookup && ((r_act == ACT_EVICT) || (match != '0))) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (IDX_W'(i) >= rm_idx) begin
                    r_fr[i] <= r_fr[i+1];
                    r_pr[i] <= r_pr[i+1];
                    r_fq[i] <= r_fq[i+1];
                    r_dt[i] <= r_dt[i+1];
                end
            end
            r_held <= r_held - CNT_W'(1);
        end else if (i_cmd.place) begin
            for (int i = 0; i < CAPACITY; i++) begin
                // slot takes its upper neighbor when that neighbor is at or past the gap
                if (i > 0 && live[(i > 0) ? i-1 : 0] && !gt[(i > 0) ? i-1 : 0]) begin
                    r_fr[i] <= r_fr[i-1];
                    r_pr[i] <= r_pr[i-1];
                    r_fq[i] <= r_fq[i-1];
                    r_dt[i] <= r_dt[i-1];
                end
                if ((i == 0 || gt[(i > 0) ? i-1 : 0]) && !gt[i]) begin
                    r_fr[i] <= r_s_fr;
                    r_pr[i] <= r_s_pr;
                    r_fq[i] <= r_s_fq;
                    r_dt[i] <= r_s_dt;
                end
            end
            r_held <= r_held + CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status      <= i_status;
            o_entry_count <= COUNT_W'(r_held);
            if (i_status == ST_OK) begin
                o_out_frame_index <= r_s_fr;
                o_out_process_id  <= r_s_pr;
                o_out_frequency   <= SFREQ_W'(r_s_fq);
                o_out_dirty       <= r_s_dt;
            end else begin
                o_out_frame_index <= '0;
                o_out_process_id  <= '0;
                o_out_frequency   <= '0;
                o_out_dirty       <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/lft_ctrl.sv
// lft_ctrl: sequencer for insert, access and evict steps and the output handshake
// depends on lft_pkg
module lft_ctrl
    import lft_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_lft_sts i_sts,
    output t_lft_cmd o_cmd,
    output t_status  o_status
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_PLACE  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state  r_state, n_state;
    logic    r_valid, n_valid;
    logic    out_free;

    assign out_free = !r_valid || !i_stall;
    assign o_valid  = r_valid;
    assign o_stall  = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        o_cmd    = '0;
        o_status = ST_OK;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_sts.action == ACT_INSERT) begin
                    if (i_sts.full) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.place = 1'b1;
                        n_state     = S_DONE;
                    end
                end else if (i_sts.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.lookup = 1'b1;
                    n_state = (i_sts.action == ACT_EVICT) ? S_DONE : S_PLACE;
                end
            end
            S_PLACE: begin
                if (i_sts.hit) begin
                    o_cmd.place = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.action == ACT_INSERT) begin
                    o_status = i_sts.full && !i_sts.hit ? ST_FULL : ST_OK;
                end else if (!i_sts.hit) begin
                    o_status = i_sts.empty ? ST_EMPTY : ST_MISSING;
                end
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

FILE: rtl/lfu_frame_table.sv
// lfu_frame_table: frequency ordered page frame table; an item steps through load,
// compare and shift, and result, where the result step waits for a free result
// register, and an access adds a step, as it removes and then reinserts its entry;
// the sorted shift chain compares all slots at once, however many are held.
// Results wait in an output register while the next item is loaded.
module lfu_frame_table
    import lft_pkg::*;
#(
    parameter int unsigned CAPACITY  = 16,
    parameter int unsigned FREQ_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [FRAME_W-1:0] i_frame_index,
    input  logic [PROC_W-1:0]  i_process_id,
    input  logic [SFREQ_W-1:0] i_start_frequency,
    input  logic               i_start_dirty,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [FRAME_W-1:0] o_out_frame_index,
    output logic [PROC_W-1:0]  o_out_process_id,
    output logic [SFREQ_W-1:0] o_out_frequency,
    output logic               o_out_dirty,
    output logic [COUNT_W-1:0] o_entry_count
);

    t_lft_cmd cmd;
    t_lft_sts sts;
    t_status  status;

    lft_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_status (status)
    );

    lft_datapath #(
        .CAPACITY  (CAPACITY),
        .FREQ_BITS (FREQ_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_frame_index     (i_frame_index),
        .i_process_id      (i_process_id),
        .i_start_frequency (i_start_frequency),
        .i_start_dirty     (i_start_dirty),
        .i_status          (status),
        .o_status          (o_status),
        .o_out_frame_index (o_out_frame_index),
        .o_out_process_id  (o_out_process_id),
        .o_out_frequency   (o_out_frequency),
        .o_out_dirty       (o_out_dirty),
        .o_entry_count     (o_entry_count)
    );

endmodule

FILE: rtl/lft_checker.sv
// lft_checker: port level checks for lfu_frame_table
// depends on lft_pkg, bound to lfu_frame_table
module lft_checker
    import lft_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_status,
    input logic [FRAME_W-1:0] o_out_frame_index,
    input logic [COUNT_W-1:0] o_entry_count
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_frame_index))
        else $error("result changed under stall");

    // a failed step reports a zero frame
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_out_frame_index == '0)
        else $error("failed step shows frame data");

    // empty status only with an empty table
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_entry_count == '0)
        else $error("empty status with entries held");

    // an accepted item blocks the input for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken back to back");

endmodule

bind lfu_frame_table lft_checker u_lft_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_status          (o_status),
    .o_out_frame_index (o_out_frame_index),
    .o_entry_count     (o_entry_count)
);

FILE: tb/tb.sv
// tb: self-checking testbench for lfu_frame_table
// depends on lft_pkg and the lfu_frame_table rtl
module tb
    import lft_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 16;
    localparam logic [15:0] FMAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] frame;
        logic [14:0] proc_id;
        logic [15:0] freq;
        logic        dirty;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] frame;
        logic [14:0] proc_id;
        logic [15:0] freq;
        logic        dirty;
        logic [4:0]  count;
    } t_res;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0;
    logic [1:0] i_action = 0;
    logic [15:0] i_frame_index = 0;
    logic [14:0] i_process_id = 0;
    logic [15:0] i_start_frequency = 0;
    logic i_start_dirty = 0;
    logic o_stall, o_valid, o_out_dirty;
    logic [1:0] o_status;
    logic [15:0] o_out_frame_index, o_out_frequency;
    logic [14:0] o_out_process_id;
    logic [4:0] o_entry_count;

    lfu_frame_table dut (.*);

    initial forever #2 i_clk = ~i_clk;

    // table model: slots 0..held-1, head first
    logic [15:0] tf [CAP];
    logic [14:0] tp [CAP];
    logic [15:0] tq [CAP];
    logic        td [CAP];
    int held = 0;

    t_req pending[$];
    t_res expected_res[$];
    int errors = 0;
    bit hold_rx = 0;
    bit gen_done = 0;

    function automatic logic [15:0] bump(logic [15:0] f);
        return (f == FMAX) ? FMAX : f + 16'd1;
    endfunction

    task automatic take_out(int pos);
        for (int i = pos; i + 1 < held; i++) begin
            tf[i] = tf[i+1]; tp[i] = tp[i+1]; tq[i] = tq[i+1]; td[i] = td[i+1];
        end
        held--;
    endtask

    task automatic put_in(logic [15:0] f, logic [14:0] p, logic [15:0] q, logic d);
        int pos;
        pos = 0;
        while (pos < held && tq[pos] > q) pos++;
        for (int i = held; i > pos; i--) begin
            tf[i] = tf[i-1]; tp[i] = tp[i-1]; tq[i] = tq[i-1]; td[i] = td[i-1];
        end
        tf[pos] = f; tp[pos] = p; tq[pos] = q; td[pos] = d;
        held++;
    endtask

    // predict the result of one accepted item
    task automatic predict_table(t_req r);
        t_res e;
        int pos;
        e = '0;
        e.status = ST_OK;
        case (t_action'(r.action))
            ACT_INSERT: begin
                if (held >= CAP) e.status = ST_FULL;
                else begin
                    e.frame = r.frame; e.proc_id = r.proc_id;
                    e.freq = bump(r.freq); e.dirty = r.dirty;
                    put_in(e.frame, e.proc_id, e.freq, e.dirty);
                end
            end
            ACT_EVICT: begin
                if (held == 0) e.status = ST_EMPTY;
                else begin
                    e.frame = tf[held-1]; e.proc_id = tp[held-1];
                    e.freq = tq[held-1]; e.dirty = td[held-1];
                    take_out(held - 1);
                end
            end
            default: begin
                if (held == 0) e.status = ST_EMPTY;
                else begin
                    pos = 0;
                    while (pos < held && tf[pos] != r.frame) pos++;
                    if (pos >= held) e.status = ST_MISSING;
                    else begin
                        e.frame = tf[pos]; e.proc_id = tp[pos];
                        e.freq = bump(tq[pos]);
                        e.dirty = td[pos] | (r.action == ACT_WRITE);
                        take_out(pos);
                        put_in(e.frame, e.proc_id, e.freq, e.dirty);
                    end
                end
            end
        endcase
        e.count = 5'(held);
        expected_res.push_back(e);
    endtask

    // driver: bursts with random gaps
    int gap = 0, burst = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predict_table({i_action, i_frame_index, i_process_id,
                               i_start_frequency, i_start_dirty});
            end
            if (!i_valid || !o_stall) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    i_valid <= 0;
                end else if (pending.size() > 0) begin
                    t_req r;
                    r = pending.pop_front();
                    i_valid <= 1;
                    i_action <= r.action;
                    i_frame_index <= r.frame;
                    i_process_id <= r.proc_id;
                    i_start_frequency <= r.freq;
                    i_start_dirty <= r.dirty;
                    if (burst > 0) burst <= burst - 1;
                    else begin
                        burst <= $urandom_range(0, 12);
                        gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // receiver stall pattern, plus one long hold-off counted here
    int stall_mode = 0;
    int hold_left = 0;
    bit hold_done = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        if (hold_left > 0) begin
            i_stall <= 1;
            hold_left <= hold_left - 1;
        end else if (hold_rx && !hold_done) begin
            i_stall <= 1;
            hold_left <= 300;
            hold_done <= 1;
        end else case (stall_mode)
            0: i_stall <= 0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 4) != 0);
        endcase
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_res.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                t_res e;
                e = expected_res.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_out_frame_index !== e.frame) begin
                    $error("out_frame_index exp %0h got %0h", e.frame, o_out_frame_index);
                    errors++;
                end
                if (o_out_process_id !== e.proc_id) begin
                    $error("out_process_id exp %0h got %0h", e.proc_id, o_out_process_id);
                    errors++;
                end
                if (o_out_frequency !== e.freq) begin
                    $error("out_frequency exp %0h got %0h", e.freq, o_out_frequency);
                    errors++;
                end
                if (o_out_dirty !== e.dirty) begin
                    $error("out_dirty exp %0d got %0d", e.dirty, o_out_dirty); errors++;
                end
                if (o_entry_count !== e.count) begin
                    $error("entry_count exp %0d got %0d", e.count, o_entry_count); errors++;
                end
            end
        end
    end

    function automatic t_req mk(logic [1:0] a, logic [15:0] f, logic [14:0] p,
                                logic [15:0] q, logic d);
        t_req r;
        r.action = a; r.frame = f; r.proc_id = p; r.freq = q; r.dirty = d;
        return r;
    endfunction

    // stimulus
    logic [15:0] pool [8];
    initial begin
        t_req r;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        // directed: empty table, extremes, saturation, full, missing, duplicates
        pending.push_back(mk(ACT_EVICT, 0, 0, 0, 0));
        pending.push_back(mk(ACT_READ, 16'h1234, 0, 0, 0));
        pending.push_back(mk(ACT_INSERT, 16'hFFFF, 15'h7FFF, 16'hFFFF, 1));
        pending.push_back(mk(ACT_READ, 16'hFFFF, 0, 0, 0));
        pending.push_back(mk(ACT_INSERT, 16'h0000, 15'h0000, 16'h0000, 0));
        pending.push_back(mk(ACT_INSERT, 16'h0000, 15'h5555, 16'h0000, 1));
        pending.push_back(mk(ACT_WRITE, 16'h0000, 0, 0, 0));
        pending.push_back(mk(ACT_READ, 16'hAAAA, 0, 0, 0));
        pending.push_back(mk(ACT_INSERT, 16'h0007, 15'h2AAA, 16'hFFFE, 0));
        pending.push_back(mk(ACT_READ, 16'h0007, 0, 0, 0));
        for (int i = 0; i < 13; i++) pending.push_back(mk(ACT_INSERT, 16'(i + 100),
            15'(i), 16'(i % 3), i[0]));
        pending.push_back(mk(ACT_EVICT, 0, 0, 0, 0));
        while (pending.size() > 0 || expected_res.size() > 0 || i_valid) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        // random: small frame pool so accesses mostly hit
        for (int i = 0; i < 8; i++) pool[i] = 16'($urandom);
        for (int n = 0; n < 550; n++) begin
            k = $urandom_range(0, 9);
            r.frame = ($urandom_range(0, 7) == 0) ? 16'($urandom) : pool[$urandom_range(0, 7)];
            r.proc_id = 15'($urandom);
            r.freq = ($urandom_range(0, 7) == 0) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                                 : 16'($urandom_range(0, 20));
            r.dirty = 1'($urandom);
            r.action = (k < 3) ? ACT_INSERT : (k < 5) ? ACT_READ : (k < 7) ? ACT_WRITE
                      : (k < 9) ? ACT_EVICT : 2'($urandom);
            pending.push_back(r);
            if (n == 200) begin
                // long receiver hold-off while items keep coming
                hold_rx = 1;
            end
            if (n == 400) begin
                while (pending.size() > 0 || expected_res.size() > 0 || i_valid)
                    @(posedge i_clk);
            end
        end
        while (pending.size() > 0 || expected_res.size() > 0 || i_valid) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
